// ===== rtl/core/ese_pkg.sv =====
// Shared widths, request codes and the queued command type of the search engine.
package ese_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int KEY_W           = 32;
   localparam int INDEX_W         = 10;
   localparam int POS_W           = 10;
   localparam int COUNT_W         = 11;
   localparam int QUEUE_DEPTH     = 2;

   typedef enum logic {
      REQ_LOAD   = 1'b0,
      REQ_SEARCH = 1'b1
   } req_kind_type;

   typedef struct packed {
      req_kind_type              kind;
      logic [INDEX_W-1:0]        index;
      logic signed [KEY_W-1:0]   data;
   } cmd_type;

endpackage

// ===== rtl/core/exponential_search_engine.sv =====
// Top level of the exponential search engine over a table of sorted signed keys.
// A request beat is taken at a clock edge where start is high and busy is low.
// req_type selects a load, which writes req_load_value at req_load_index and gives
// no response, or a search for req_target, which gives exactly one response beat.
// The response is shown for one cycle with rsp_valid high, carrying rsp_found and
// rsp_position; the receiver cannot stall it and there is no backpressure.
// The csr channel writes the entry count, taken when csr_valid and csr_ready are
// high; csr_ready is always high. Write it only while no search is in flight.
// Requests pass through a two-beat queue, so busy rises only when it is full.
// With the sequencer idle, a load is registered in the queue and then written to the table.
// With the sequencer idle, a search reads entry 0, then makes its doubling probes and
// then its bisection steps; each probe and each bisection step waits on one table read.
// An empty table answers without a table read, and a match on entry 0 answers after
// that one read. Beats queued behind a search wait for it to finish.
// Reset empties the queue, idles the sequencer and clears the entry count; the
// table contents are not cleared.
module exponential_search_engine #(
   parameter int TABLE_DEPTH = ese_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_type,
   input  logic [ese_pkg::INDEX_W-1:0]       req_load_index,
   input  logic signed [ese_pkg::KEY_W-1:0]  req_load_value,
   input  logic signed [ese_pkg::KEY_W-1:0]  req_target,
   output logic                              rsp_valid,
   output logic                              rsp_found,
   output logic [ese_pkg::POS_W-1:0]         rsp_position,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ese_pkg::COUNT_W-1:0]       csr_entry_count
);
   import ese_pkg::*;

   logic     cmd_valid;
   logic     cmd_ready;
   cmd_type  cmd;

   ese_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_load_index (req_load_index),
      .req_load_value (req_load_value),
      .req_target     (req_target),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_ready      (cmd_ready)
   );

   ese_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_ready       (cmd_ready),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_entry_count (csr_entry_count),
      .rsp_valid       (rsp_valid),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position)
   );

endmodule

// ===== rtl/core/ese_front.sv =====
// Request intake: accepts beats, packs loads and searches into one queue for the engine.
module ese_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_type,
   input  logic [ese_pkg::INDEX_W-1:0]       req_load_index,
   input  logic signed [ese_pkg::KEY_W-1:0]  req_load_value,
   input  logic signed [ese_pkg::KEY_W-1:0]  req_target,
   output logic                              cmd_valid,
   output ese_pkg::cmd_type                  cmd,
   input  logic                              cmd_ready
);
   import ese_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_C = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_C = PTR_W'(QUEUE_DEPTH - 1);

   cmd_type            entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;
   cmd_type            new_cmd;

   assign busy      = (count_ff == FULL_C);
   assign push      = start && !busy;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = entries_ff[rd_ptr_ff];

   always_comb begin
      new_cmd.kind  = req_kind_type'(req_type);
      new_cmd.index = req_load_index;
      new_cmd.data  = (req_kind_type'(req_type) == REQ_SEARCH) ? req_target : req_load_value;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_C) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_C) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ===== rtl/core/ese_back.sv =====
// Search engine: key table memory, count register and the probe and bisection sequencer.
module ese_back #(
   parameter int TABLE_DEPTH = ese_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   input  ese_pkg::cmd_type                  cmd,
   output logic                              cmd_ready,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ese_pkg::COUNT_W-1:0]       csr_entry_count,
   output logic                              rsp_valid,
   output logic                              rsp_found,
   output logic [ese_pkg::POS_W-1:0]         rsp_position
);
   import ese_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int NW = AW + 1;
   localparam int CW = (NW > COUNT_W) ? NW : COUNT_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ZERO,
      ST_PROBE,
      ST_SETUP,
      ST_MID,
      ST_STEP
   } state_type;

   state_type                state_ff, state_in;
   logic [COUNT_W-1:0]       count_ff;
   logic [NW-1:0]            n_ff, n_in;
   logic signed [KEY_W-1:0]  target_ff, target_in;
   logic [NW-1:0]            probe_ff, probe_in;
   logic [AW-1:0]            low_ff, low_in;
   logic [AW-1:0]            high_ff, high_in;
   logic [AW-1:0]            mid_ff, mid_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]         rsp_position_ff, rsp_position_in;

   logic signed [KEY_W-1:0]  key_table [TABLE_DEPTH];
   logic signed [KEY_W-1:0]  rd_data_ff;
   logic                     rd_en, wr_en;
   logic [AW-1:0]            rd_addr, wr_addr;

   logic [CW-1:0]            count_ext;
   logic [NW-1:0]            n_clamp;
   logic [NW-1:0]            probe_dbl;
   logic [NW-1:0]            n_m1;
   logic [AW:0]              mid_sum;

   assign cmd_ready    = (state_ff == ST_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

   assign count_ext = CW'(count_ff);
   assign n_clamp   = (count_ext > DEPTH_C) ? NW'(DEPTH_C) : NW'(count_ext);
   assign probe_dbl = probe_ff << 1;
   assign n_m1      = n_ff - NW'(1);
   assign mid_sum   = {1'b0, low_ff} + {1'b0, high_ff};

   always_comb begin
      state_in        = state_ff;
      n_in            = n_ff;
      target_in       = target_ff;
      probe_in        = probe_ff;
      low_in          = low_ff;
      high_in         = high_ff;
      mid_in          = mid_ff;
      rsp_valid_in    = 1'b0;
      rsp_found_in    = rsp_found_ff;
      rsp_position_in = rsp_position_ff;
      rd_en           = 1'b0;
      rd_addr         = '0;
      wr_en           = 1'b0;
      wr_addr         = AW'(cmd.index);
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.kind == REQ_LOAD) begin
                  wr_en = (32'(cmd.index) < 32'(TABLE_DEPTH));
               end else begin
                  target_in = cmd.data;
                  n_in      = n_clamp;
                  if (n_clamp == '0) begin
                     rsp_valid_in    = 1'b1;
                     rsp_found_in    = 1'b0;
                     rsp_position_in = '0;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     state_in = ST_ZERO;
                  end
               end
            end
         end
         ST_ZERO: begin
            if (rd_data_ff == target_ff) begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = 1'b1;
               rsp_position_in = '0;
               state_in        = ST_IDLE;
            end else begin
               probe_in = NW'(1);
               if (n_ff > NW'(1)) begin
                  rd_en    = 1'b1;
                  rd_addr  = AW'(1);
                  state_in = ST_PROBE;
               end else begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_PROBE: begin
            if (rd_data_ff <= target_ff) begin
               probe_in = probe_dbl;
               if (probe_dbl < n_ff) begin
                  rd_en   = 1'b1;
                  rd_addr = AW'(probe_dbl);
               end else begin
                  state_in = ST_SETUP;
               end
            end else begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            low_in   = AW'(probe_ff >> 1);
            high_in  = (probe_ff < n_m1) ? AW'(probe_ff) : AW'(n_m1);
            state_in = ST_MID;
         end
         ST_MID: begin
            mid_in   = mid_sum[AW:1];
            rd_en    = 1'b1;
            rd_addr  = mid_sum[AW:1];
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (rd_data_ff == target_ff) begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = 1'b1;
               rsp_position_in = POS_W'(mid_ff);
               state_in        = ST_IDLE;
            end else if (rd_data_ff < target_ff) begin
               if (mid_ff == high_ff) begin
                  rsp_valid_in    = 1'b1;
                  rsp_found_in    = 1'b0;
                  rsp_position_in = '0;
                  state_in        = ST_IDLE;
               end else begin
                  low_in   = mid_ff + AW'(1);
                  state_in = ST_MID;
               end
            end else begin
               if (mid_ff == low_ff) begin
                  rsp_valid_in    = 1'b1;
                  rsp_found_in    = 1'b0;
                  rsp_position_in = '0;
                  state_in        = ST_IDLE;
               end else begin
                  high_in  = mid_ff - AW'(1);
                  state_in = ST_MID;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            count_ff <= csr_entry_count;
         end
      end
      n_ff            <= n_in;
      target_ff       <= target_in;
      probe_ff        <= probe_in;
      low_ff          <= low_in;
      high_ff         <= high_in;
      mid_ff          <= mid_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_table[wr_addr] <= cmd.data;
      end
      if (rd_en) begin
         rd_data_ff <= key_table[rd_addr];
      end
   end

endmodule

// ===== verif/tb_exponential_search_engine.sv =====
// Self-checking testbench for the exponential search engine: directed table, then random phases.
`timescale 1ns / 100ps

module tb_exponential_search_engine;
   import ese_pkg::*;

   localparam int DEPTH        = TABLE_DEPTH_DEF;
   localparam int SETTLE_LEN   = 48;
   localparam int ITEM_GOAL    = 450;
   localparam int FILL_CAP     = 32;
   localparam int KEY_TRIES    = 8;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
   } answer_type;

   typedef enum logic [1:0] {
      ROW_LOAD,
      ROW_SEARCH,
      ROW_COUNT
   } row_op_type;

   typedef struct {
      row_op_type              op;
      logic [INDEX_W-1:0]      index;
      logic signed [KEY_W-1:0] value;
      bit                      typed;
      answer_type              answer;
   } stim_row_type;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic                     req_type;
   logic [INDEX_W-1:0]       req_load_index;
   logic signed [KEY_W-1:0]  req_load_value;
   logic signed [KEY_W-1:0]  req_target;
   logic                     rsp_valid;
   logic                     rsp_found;
   logic [POS_W-1:0]         rsp_position;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [COUNT_W-1:0]       csr_entry_count;

   logic signed [KEY_W-1:0]  shadow_keys [DEPTH];
   bit                       shadow_written [DEPTH];
   logic [COUNT_W-1:0]       shadow_count;
   answer_type               pending_answers [$];
   stim_row_type             directed_rows [$];
   bit                       gaps_on;
   int unsigned              searches_sent;
   int unsigned              hits_sent;
   int unsigned              loads_sent;
   int unsigned              count_writes;
   int unsigned              fail_count;

   exponential_search_engine uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_load_index  (req_load_index),
      .req_load_value  (req_load_value),
      .req_target      (req_target),
      .rsp_valid       (rsp_valid),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_entry_count (csr_entry_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   // The blind flag is set when the walk reads an entry that was never loaded.
   function automatic void exp_search(input logic signed [KEY_W-1:0] key,
                                      output answer_type ans, output bit blind);
      longint  n;
      longint  probe;
      longint  lo;
      longint  hi;
      longint  mid;
      ans   = '0;
      blind = 1'b0;
      n = (shadow_count > DEPTH) ? DEPTH : shadow_count;
      if (n == 0) return;
      if (!shadow_written[0]) blind = 1'b1;
      if (shadow_keys[0] == key) begin
         ans.found = 1'b1;
         return;
      end
      probe = 1;
      while (probe < n) begin
         if (!shadow_written[probe]) blind = 1'b1;
         if (shadow_keys[probe] > key) break;
         probe = probe * 2;
      end
      lo = probe / 2;
      hi = (probe < n - 1) ? probe : n - 1;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (!shadow_written[mid]) blind = 1'b1;
         if (shadow_keys[mid] == key) begin
            ans.found    = 1'b1;
            ans.position = mid[POS_W-1:0];
            return;
         end
         if (shadow_keys[mid] < key) lo = mid + 1;
         else hi = mid - 1;
      end
   endfunction

   task automatic send_request(input req_kind_type kind, input logic [INDEX_W-1:0] idx,
                               input logic signed [KEY_W-1:0] val,
                               input logic signed [KEY_W-1:0] key,
                               input bit typed, input answer_type typed_answer);
      answer_type ans;
      bit         blind;
      if (gaps_on && $urandom_range(0, 99) < 20) begin
         start = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_type       = kind;
      req_load_index = idx;
      req_load_value = val;
      req_target     = key;
      start          = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      if (kind == REQ_LOAD) begin
         shadow_keys[idx]    = val;
         shadow_written[idx] = 1'b1;
         loads_sent++;
      end else begin
         if (typed) ans = typed_answer;
         else exp_search(key, ans, blind);
         pending_answers.push_back(ans);
         searches_sent++;
         if (ans.found) hits_sent++;
      end
   endtask

   task automatic settle();
      start = 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
      repeat (SETTLE_LEN) @(negedge clock);
   endtask

   task automatic write_count(input logic [COUNT_W-1:0] value);
      settle();
      csr_entry_count = value;
      csr_valid       = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid    = 1'b0;
      shadow_count = value;
      count_writes++;
   endtask

   task automatic fill_table(input int unsigned n, input bit scrambled);
      longint      v;
      int unsigned step_max;
      int unsigned mode;
      mode = $urandom_range(0, 4);
      case (mode)
         0: step_max = 1;
         1: step_max = 3;
         2: step_max = 200;
         3: step_max = 1 << 20;
         default: step_max = 32'hFFFF_FFFF / (n + 1);
      endcase
      if (mode == 4) v = -64'sd2147483648 + $urandom_range(0, 3);
      else v = longint'($signed($urandom));
      for (int i = 0; i < n; i++) begin
         send_request(REQ_LOAD, i[INDEX_W-1:0], scrambled ? $urandom : v[KEY_W-1:0],
                      $urandom, 1'b0, '0);
         v = v + $urandom_range(0, step_max);
         if (v > 64'sd2147483647) v = 64'sd2147483647;
      end
   endtask

   task automatic add_row(input row_op_type op, input int unsigned idx, input longint value,
                          input bit typed, input bit found, input int unsigned pos);
      stim_row_type row;
      row.op              = op;
      row.index           = idx[INDEX_W-1:0];
      row.value           = value[KEY_W-1:0];
      row.typed           = typed;
      row.answer.found    = found;
      row.answer.position = pos[POS_W-1:0];
      directed_rows.push_back(row);
   endtask

   always @(posedge clock) begin : rsp_check
      answer_type ans;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("%0t: unexpected result beat found=%0b position=%0d",
                        $realtime, rsp_found, rsp_position);
         end else begin
            ans = pending_answers.pop_front();
            if (rsp_found !== ans.found || rsp_position !== ans.position) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: mismatch expected found=%0b position=%0d, %s%0b %s%0d",
                           $realtime, ans.found, ans.position,
                           "got found=", rsp_found, "position=", rsp_position);
            end
         end
      end
   end

   initial begin
      int unsigned             phase;
      int unsigned             cfg;
      int unsigned             live;
      int unsigned             filled;
      int unsigned             tries;
      int unsigned             r;
      logic signed [KEY_W-1:0] key;
      answer_type              ans;
      bit                      blind;

      reset           = 1'b1;
      start           = 1'b0;
      req_type        = REQ_LOAD;
      req_load_index  = '0;
      req_load_value  = '0;
      req_target      = '0;
      csr_valid       = 1'b0;
      csr_entry_count = '0;
      shadow_count    = '0;
      gaps_on         = 1'b0;
      searches_sent   = 0;
      hits_sent       = 0;
      loads_sent      = 0;
      count_writes    = 0;
      fail_count      = 0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // An empty table answers not found whatever the target.
      add_row(ROW_SEARCH, 0, 0, 1, 0, 0);
      add_row(ROW_SEARCH, 0, 2147483647, 1, 0, 0);
      add_row(ROW_LOAD, 0, -2147483648, 0, 0, 0);
      add_row(ROW_LOAD, 1, -1000, 0, 0, 0);
      add_row(ROW_LOAD, 2, -1, 0, 0, 0);
      add_row(ROW_LOAD, 3, 0, 0, 0, 0);
      add_row(ROW_LOAD, 4, 0, 0, 0, 0);
      add_row(ROW_LOAD, 5, 5, 0, 0, 0);
      add_row(ROW_LOAD, 6, 2147483646, 0, 0, 0);
      add_row(ROW_LOAD, 1023, 2147483647, 0, 0, 0);
      add_row(ROW_LOAD, 7, 2147483647, 0, 0, 0);
      add_row(ROW_SEARCH, 0, -2147483648, 1, 0, 0);
      add_row(ROW_COUNT, 0, 8, 0, 0, 0);
      // A match on the first entry answers position zero at once.
      add_row(ROW_SEARCH, 0, -2147483648, 1, 1, 0);
      add_row(ROW_SEARCH, 0, 2147483647, 0, 0, 0);
      add_row(ROW_SEARCH, 0, 0, 0, 0, 0);
      add_row(ROW_SEARCH, 0, 1, 0, 0, 0);
      add_row(ROW_SEARCH, 0, -2147483647, 0, 0, 0);
      add_row(ROW_SEARCH, 0, 5, 0, 0, 0);
      add_row(ROW_COUNT, 0, 1, 0, 0, 0);
      add_row(ROW_SEARCH, 0, 5, 0, 0, 0);
      // Breaking the order of the table must still give a bounded search.
      add_row(ROW_LOAD, 2, 1000, 0, 0, 0);
      add_row(ROW_COUNT, 0, 6, 0, 0, 0);
      add_row(ROW_SEARCH, 0, 1000, 0, 0, 0);
      add_row(ROW_SEARCH, 0, 0, 0, 0, 0);

      foreach (directed_rows[i]) begin
         case (directed_rows[i].op)
            ROW_LOAD: begin
               send_request(REQ_LOAD, directed_rows[i].index, directed_rows[i].value,
                            $urandom, 1'b0, '0);
            end
            ROW_SEARCH: begin
               send_request(REQ_SEARCH, INDEX_W'($urandom), $urandom,
                            directed_rows[i].value, directed_rows[i].typed,
                            directed_rows[i].answer);
            end
            default: begin
               write_count(directed_rows[i].value[COUNT_W-1:0]);
            end
         endcase
      end

      // Each phase loads a prefix of the table, plus random loads at any index; searches
      // that would read an entry never loaded are replaced by other targets.
      phase = 0;
      while (loads_sent + searches_sent < ITEM_GOAL) begin
         case (phase)
            0: cfg = 1;
            1: cfg = 2;
            2: cfg = DEPTH;
            3: cfg = 2047;
            4: cfg = $urandom_range(DEPTH + 1, 2046);
            5: cfg = 0;
            6: cfg = DEPTH - 1;
            default: begin
               r = $urandom_range(0, 99);
               if (r < 85) cfg = $urandom_range(1, 48);
               else if (r < 93) cfg = $urandom_range(49, 300);
               else if (r < 97) cfg = 0;
               else cfg = $urandom_range(DEPTH + 1, 2047);
            end
         endcase
         write_count(cfg[COUNT_W-1:0]);
         live    = (cfg > DEPTH) ? DEPTH : cfg;
         filled  = (live > FILL_CAP) ? FILL_CAP : live;
         gaps_on = (loads_sent + searches_sent < 150 || loads_sent + searches_sent > 300);
         fill_table(filled, $urandom_range(0, 99) < 15);
         repeat ($urandom_range(4, 20)) begin
            gaps_on = (loads_sent + searches_sent < 150 ||
                       loads_sent + searches_sent > 300);
            r = $urandom_range(0, 99);
            if (r < 10) begin
               send_request(REQ_LOAD, INDEX_W'($urandom), $urandom, $urandom, 1'b0, '0);
            end else begin
               tries = 0;
               blind = 1'b1;
               while (blind && tries < KEY_TRIES) begin
                  r   = $urandom_range(0, 99);
                  key = (filled == 0) ? KEY_W'($urandom)
                                      : shadow_keys[$urandom_range(0, filled - 1)];
                  if (r < 10) key = key + 1;
                  else if (r < 20) key = key - 1;
                  else if (r < 28) key = 32'sh8000_0000;
                  else if (r < 35) key = 32'sh7FFF_FFFF;
                  else if (r < 50) key = $urandom;
                  exp_search(key, ans, blind);
                  tries++;
               end
               if (blind) key = shadow_keys[0];
               send_request(REQ_SEARCH, INDEX_W'($urandom), $urandom, key, 1'b0, '0);
            end
         end
         phase++;
      end

      settle();
      $display("Covered %0d searches (%0d hits) and %0d table loads across %0d entry counts,",
               searches_sent, hits_sent, loads_sent, count_writes);
      $display("including an empty table, full and saturated counts, and unsorted tables.");
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== exponential_search_engine.f =====
rtl/core/ese_pkg.sv
rtl/core/ese_front.sv
rtl/core/ese_back.sv
rtl/core/exponential_search_engine.sv
verif/tb_exponential_search_engine.sv
